FILE: design/hsv_to_rgb_converter_defines.svh
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Checks are clocked on clk and held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Same-cycle implication.
`define HSV_ASSERT_IMPLY(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("hsv_to_rgb_converter: implication check failed");

// Implication after a fixed number of cycles.
`define HSV_ASSERT_LATENCY(label, a, n, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> ##n (b)) \
    else $error("hsv_to_rgb_converter: latency check failed");

`endif

FILE: design/hsv_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Request and result types, pipeline stage types and fixed constants.
// ----------------------------------------------------------------------------
package hsv_pkg;

  localparam int HUE_WIDTH      = 15;
  localparam int HUE_PER_SECTOR = 3840;
  localparam int SECTORS        = 6;
  localparam int FULL_SCALE     = 255;
  localparam int MAX_TURNS      = (2 ** HUE_WIDTH - 1) / HUE_PER_SECTOR;
  localparam int SECTOR_ONE     = 256 * HUE_PER_SECTOR;
  localparam int CLAMP_LIMIT    = FULL_SCALE * 15;
  localparam int RECIP_15       = 4370;
  localparam int PIPE_LATENCY   = 5;

  typedef enum logic [2:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5
  } sector_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [8:0]  saturation;
    logic [8:0]  brightness;
    logic [7:0]  alpha_in;
  } hsv_pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_out;
  } rgb_pixel_t;

  typedef struct packed {
    logic        valid;
    sector_t     sector;
    logic [11:0] frac;
    logic [8:0]  sat;
    logic [16:0] scaled;
    logic [7:0]  alpha;
  } sect_stage_t;

  typedef struct packed {
    logic        valid;
    sector_t     sector;
    logic [19:0] q_mult;
    logic [19:0] t_mult;
    logic [8:0]  p_mult;
    logic [16:0] scaled;
    logic [7:0]  alpha;
  } mid_stage_t;

  typedef struct packed {
    logic        valid;
    sector_t     sector;
    logic [12:0] q_raw;
    logic [12:0] t_raw;
    logic [9:0]  p_raw;
    logic [8:0]  v_raw;
    logic [7:0]  alpha;
  } prod_stage_t;

  typedef struct packed {
    logic       valid;
    sector_t    sector;
    logic [7:0] v_byte;
    logic [7:0] p_byte;
    logic [7:0] q_byte;
    logic [7:0] t_byte;
    logic [7:0] alpha;
  } byte_stage_t;

endpackage

FILE: design/hsv_sector.sv
// ----------------------------------------------------------------------------
// HSV sector stage
// Splits hue into sector and fraction, scales brightness by 255.
// ----------------------------------------------------------------------------
module hsv_sector (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  hsv_pkg::hsv_pixel_t pixel,
  output hsv_pkg::sect_stage_t stage
);
  import hsv_pkg::*;

  logic [3:0]  turns;
  logic [3:0]  wrapped;
  logic [14:0] base;
  sect_stage_t stage_next;

  always_comb begin
    turns = '0;
    for (int i = 1; i <= MAX_TURNS; i++) begin
      if (pixel.hue >= 15'(i * HUE_PER_SECTOR)) begin
        turns = 4'(i);
      end
    end
    base    = 15'(turns) * 15'(HUE_PER_SECTOR);
    wrapped = (turns >= 4'(SECTORS)) ? turns - 4'(SECTORS) : turns;

    stage_next.valid  = load;
    stage_next.sector = sector_t'(wrapped[2:0]);
    stage_next.frac   = 12'(pixel.hue - base);
    stage_next.sat    = pixel.saturation;
    stage_next.scaled = {pixel.brightness, 8'd0} - 17'(pixel.brightness);
    stage_next.alpha  = pixel.alpha_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= stage_next;
    end
  end

endmodule

FILE: design/hsv_product.sv
// ----------------------------------------------------------------------------
// HSV product stages
// Forms the p, q and t multipliers, then multiplies them by scaled value.
// ----------------------------------------------------------------------------
module hsv_product (
  input  logic                 clk,
  input  logic                 rst,
  input  hsv_pkg::sect_stage_t in_stage,
  output hsv_pkg::prod_stage_t out_stage
);
  import hsv_pkg::*;

  logic [20:0] fs;
  logic [20:0] gs;
  logic [36:0] q_prod;
  logic [36:0] t_prod;
  logic [25:0] p_prod;
  mid_stage_t  mid;
  mid_stage_t  mid_next;
  prod_stage_t out_next;

  always_comb begin
    fs = 21'(in_stage.frac) * 21'(in_stage.sat);
    gs = 21'(12'(HUE_PER_SECTOR) - in_stage.frac) * 21'(in_stage.sat);

    mid_next.valid  = in_stage.valid;
    mid_next.sector = in_stage.sector;
    mid_next.q_mult = (fs < 21'(SECTOR_ONE)) ? 20'(21'(SECTOR_ONE) - fs) : '0;
    mid_next.t_mult = (gs < 21'(SECTOR_ONE)) ? 20'(21'(SECTOR_ONE) - gs) : '0;
    mid_next.p_mult = in_stage.sat[8] ? '0 : 9'(9'd256 - in_stage.sat);
    mid_next.scaled = in_stage.scaled;
    mid_next.alpha  = in_stage.alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid <= '0;
    end else begin
      mid <= mid_next;
    end
  end

  always_comb begin
    q_prod = 37'(mid.scaled) * 37'(mid.q_mult);
    t_prod = 37'(mid.scaled) * 37'(mid.t_mult);
    p_prod = 26'(mid.scaled) * 26'(mid.p_mult);

    out_next.valid  = mid.valid;
    out_next.sector = mid.sector;
    out_next.q_raw  = q_prod[36:24];
    out_next.t_raw  = t_prod[36:24];
    out_next.p_raw  = p_prod[25:16];
    out_next.v_raw  = mid.scaled[16:8];
    out_next.alpha  = mid.alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stage <= '0;
    end else begin
      out_stage <= out_next;
    end
  end

endmodule

FILE: design/hsv_route.sv
// ----------------------------------------------------------------------------
// HSV route stages
// Finishes the divide by 15, clamps to bytes and routes by sector.
// ----------------------------------------------------------------------------
module hsv_route (
  input  logic                 clk,
  input  logic                 rst,
  input  hsv_pkg::prod_stage_t in_stage,
  output logic                 done,
  output hsv_pkg::rgb_pixel_t  color
);
  import hsv_pkg::*;

  byte_stage_t bytes;
  byte_stage_t bytes_next;
  rgb_pixel_t  color_next;

  function automatic logic [7:0] div15_byte(logic [12:0] y);
    logic [24:0] prod;
    prod = 25'(y[11:0]) * 25'(RECIP_15);
    return (y >= 13'(CLAMP_LIMIT)) ? 8'hFF : prod[23:16];
  endfunction

  function automatic logic [7:0] clamp_byte(logic [9:0] x);
    return (x > 10'(FULL_SCALE)) ? 8'hFF : x[7:0];
  endfunction

  always_comb begin
    bytes_next.valid  = in_stage.valid;
    bytes_next.sector = in_stage.sector;
    bytes_next.v_byte = clamp_byte(10'(in_stage.v_raw));
    bytes_next.p_byte = clamp_byte(in_stage.p_raw);
    bytes_next.q_byte = div15_byte(in_stage.q_raw);
    bytes_next.t_byte = div15_byte(in_stage.t_raw);
    bytes_next.alpha  = in_stage.alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes <= '0;
    end else begin
      bytes <= bytes_next;
    end
  end

  always_comb begin
    color_next.alpha_out = bytes.alpha;
    unique case (bytes.sector)
      SECTOR_0: begin
        color_next.red   = bytes.v_byte;
        color_next.green = bytes.t_byte;
        color_next.blue  = bytes.p_byte;
      end
      SECTOR_1: begin
        color_next.red   = bytes.q_byte;
        color_next.green = bytes.v_byte;
        color_next.blue  = bytes.p_byte;
      end
      SECTOR_2: begin
        color_next.red   = bytes.p_byte;
        color_next.green = bytes.v_byte;
        color_next.blue  = bytes.t_byte;
      end
      SECTOR_3: begin
        color_next.red   = bytes.p_byte;
        color_next.green = bytes.q_byte;
        color_next.blue  = bytes.v_byte;
      end
      SECTOR_4: begin
        color_next.red   = bytes.t_byte;
        color_next.green = bytes.p_byte;
        color_next.blue  = bytes.v_byte;
      end
      default: begin
        color_next.red   = bytes.v_byte;
        color_next.green = bytes.p_byte;
        color_next.blue  = bytes.q_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    color <= color_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= bytes.valid;
    end
  end

endmodule

FILE: design/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Five-stage pipeline turning one HSV pixel into an RGB pixel per clock.
// ----------------------------------------------------------------------------
// Takes one request per clock: busy is always low, so a request is taken
// whenever start is high. Each result appears on color with done high for
// exactly one cycle, five cycles after its request, and must be captured
// then. The five register stages are hue split and value scaling, the p/q/t
// multiplier setup, the value-by-multiplier products, the divide by 15 and
// byte clamp, and the sector routing into the output register.
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  hsv_pkg::hsv_pixel_t pixel,
  output logic                done,
  output hsv_pkg::rgb_pixel_t color
);
  import hsv_pkg::*;

  logic        load;
  sect_stage_t sect;
  prod_stage_t prod;

  assign busy = 1'b0;
  assign load = start && !busy;

  hsv_sector u_sector (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .pixel (pixel),
    .stage (sect)
  );

  hsv_product u_product (
    .clk       (clk),
    .rst       (rst),
    .in_stage  (sect),
    .out_stage (prod)
  );

  hsv_route u_route (
    .clk      (clk),
    .rst      (rst),
    .in_stage (prod),
    .done     (done),
    .color    (color)
  );

  `HSV_ASSERT_LATENCY(a_request_yields_result, load, PIPE_LATENCY, done)
  `HSV_ASSERT_IMPLY(a_result_has_request, done, $past(load, PIPE_LATENCY))
  `HSV_ASSERT_IMPLY(a_alpha_follows, done, color.alpha_out == $past(pixel.alpha_in, PIPE_LATENCY))

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Sends HSV pixels with random gaps and predicts each RGB result in the
// scoreboard. Every done pulse is compared field by field with the oldest
// prediction. Covers sector edges, hue past 360 degrees and saturation or
// value above 1.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import hsv_pkg::*;

  localparam int PIXEL_COUNT = 1000;
  localparam int CYCLE_LIMIT = 200000;

  class pixel_scoreboard;
    rgb_pixel_t expected_q[$];
    int         mismatches;
    int         checked;

    function logic [7:0] clip_byte(longint num, longint den);
      longint r;
      if (num <= 0) return 8'd0;
      r = num / den;
      if (r > FULL_SCALE) r = FULL_SCALE;
      return r[7:0];
    endfunction

    function rgb_pixel_t convert(hsv_pixel_t px);
      longint     h, s, b, f, vs, one, den;
      logic [7:0] v, p, q, t;
      sector_t    sec;
      rgb_pixel_t res;
      h   = longint'(px.hue);
      s   = longint'(px.saturation);
      b   = longint'(px.brightness);
      f   = h % HUE_PER_SECTOR;
      vs  = b * FULL_SCALE;
      one = 256 * HUE_PER_SECTOR;
      den = 256 * one;
      sec = sector_t'((h / HUE_PER_SECTOR) % SECTORS);
      v = clip_byte(vs, 256);
      p = clip_byte(vs * (256 - s), 65536);
      q = clip_byte(vs * (one - f * s), den);
      t = clip_byte(vs * (one - (HUE_PER_SECTOR - f) * s), den);
      case (sec)
        SECTOR_0: begin res.red = v; res.green = t; res.blue = p; end
        SECTOR_1: begin res.red = q; res.green = v; res.blue = p; end
        SECTOR_2: begin res.red = p; res.green = v; res.blue = t; end
        SECTOR_3: begin res.red = p; res.green = q; res.blue = v; end
        SECTOR_4: begin res.red = t; res.green = p; res.blue = v; end
        default: begin res.red = v; res.green = p; res.blue = q; end
      endcase
      res.alpha_out = px.alpha_in;
      return res;
    endfunction

    function void note(hsv_pixel_t px);
      expected_q.push_back(convert(px));
    endfunction

    function void check(rgb_pixel_t got);
      rgb_pixel_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result r=%0d g=%0d b=%0d a=%0d",
                   got.red, got.green, got.blue, got.alpha_out);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.alpha_out !== want.alpha_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                   want.red, want.green, want.blue, want.alpha_out,
                   got.red, got.green, got.blue, got.alpha_out);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       done;
  hsv_pixel_t pixel = '0;
  rgb_pixel_t color;

  pixel_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  int hue_wraps = 0;
  int over_range = 0;

  hsv_to_rgb_converter dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .pixel (pixel),
    .done  (done),
    .color (color)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check(color);
  end

  function automatic hsv_pixel_t make_pixel(int h, int s, int b, int a);
    hsv_pixel_t px;
    px.hue        = h[14:0];
    px.saturation = s[8:0];
    px.brightness = b[8:0];
    px.alpha_in   = a[7:0];
    return px;
  endfunction

  function automatic hsv_pixel_t random_pixel();
    if ($urandom_range(0, 9) < 8)
      return make_pixel($urandom_range(0, 23039), $urandom_range(0, 256),
                        $urandom_range(0, 256), $urandom_range(0, 255));
    return make_pixel($urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic send_pixel(input hsv_pixel_t px, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (busy);
    sb.note(px);
    sent++;
    if (px.hue >= 15'd23040) hue_wraps++;
    if (px.saturation > 9'd256 || px.brightness > 9'd256) over_range++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    hsv_pixel_t directed[$];
    bit         burst;
    int         gap;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed.push_back(make_pixel(0, 0, 0, 0));
    directed.push_back(make_pixel(0, 256, 256, 255));
    directed.push_back(make_pixel(3839, 256, 256, 1));
    directed.push_back(make_pixel(3840, 256, 256, 2));
    directed.push_back(make_pixel(7680, 128, 256, 3));
    directed.push_back(make_pixel(11520, 256, 200, 4));
    directed.push_back(make_pixel(15360, 256, 256, 5));
    directed.push_back(make_pixel(19200, 100, 256, 6));
    directed.push_back(make_pixel(23039, 256, 256, 7));
    directed.push_back(make_pixel(23040, 256, 256, 8));
    directed.push_back(make_pixel(26880, 200, 180, 9));
    directed.push_back(make_pixel(30719, 256, 256, 10));
    directed.push_back(make_pixel(32767, 511, 511, 255));
    directed.push_back(make_pixel(1920, 511, 256, 128));
    directed.push_back(make_pixel(9600, 511, 511, 170));
    directed.push_back(make_pixel(17280, 300, 400, 85));
    directed.push_back(make_pixel(5000, 0, 511, 0));
    directed.push_back(make_pixel(12000, 256, 511, 255));
    directed.push_back(make_pixel(21000, 256, 257, 60));
    directed.push_back(make_pixel(1, 257, 1, 90));
    directed.push_back(make_pixel(3841, 1, 255, 33));
    foreach (directed[i]) send_pixel(directed[i], i % 3);
    drain();

    burst = 1'b0;
    for (int i = 0; i < PIXEL_COUNT; i++) begin
      if (i % 100 == 0) burst = $urandom_range(0, 2) == 0;
      if (i == PIXEL_COUNT / 2) drain();
      gap = burst ? 0 : $urandom_range(0, 11);
      send_pixel(random_pixel(), gap);
    end
    drain();
    repeat (PIPE_LATENCY * 4) @(posedge clk);

    $display("summary: %0d pixels sent, %0d results checked, %0d mismatches",
             sent, sb.checked, sb.mismatches);
    $display("summary: %0d with hue past 360 degrees, %0d with saturation or value above 1.0",
             hue_wraps, over_range);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end
endmodule
